// File: src/day_count_year_fraction_assert.svh
// ----------------------------------------------------------------------------
// day_count_year_fraction_assert.svh
// Assertion macros shared by the day-count year-fraction RTL.
// ----------------------------------------------------------------------------
`ifndef DAY_COUNT_YEAR_FRACTION_ASSERT_SVH
`define DAY_COUNT_YEAR_FRACTION_ASSERT_SVH
`ifndef SYNTHESIS
`define DCYF_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dcyf: same-cycle check failed");
`define DCYF_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dcyf: next-cycle check failed");
`else
`define DCYF_ASSERT_IMP(name, ante, cons)
`define DCYF_ASSERT_NXT(name, ante, cons)
`endif
`endif

// File: src/dcyf_pkg.sv
// ----------------------------------------------------------------------------
// dcyf_pkg
// Types, codes and calendar tables for the day-count year-fraction block.
// ----------------------------------------------------------------------------
`default_nettype none

package dcyf_pkg;

  localparam logic [3:0] CONV_ACT360   = 4'd0;
  localparam logic [3:0] CONV_ACT365F  = 4'd1;
  localparam logic [3:0] CONV_ACT365NL = 4'd2;
  localparam logic [3:0] CONV_ISDA     = 4'd3;
  localparam logic [3:0] CONV_ICMA     = 4'd4;
  localparam logic [3:0] CONV_30US     = 4'd5;
  localparam logic [3:0] CONV_30E      = 4'd6;
  localparam logic [3:0] CONV_30EISDA  = 4'd7;
  localparam logic [3:0] CONV_ONE      = 4'd8;

  localparam logic [1:0] CFG_CONVENTION = 2'd0;
  localparam logic [1:0] CFG_EVENTS     = 2'd1;

  localparam int MAG_W = 24;  // numerator magnitude
  localparam int DEN_W = 27;  // denominator, up to 15 * 2^23
  localparam int DT_W  = 25;  // signed day differences

  // floor(x/100) = (x * RECIP100) >> RECIP_SHIFT for x below 2^15
  localparam logic [17:0] RECIP100    = 18'd167773;
  localparam int          RECIP_SHIFT = 24;

  localparam logic [22:0] DAY_LIMIT = 23'd3652059;

  localparam logic [4:0] MONTH_LEN [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                            5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};
  // days before the first of each month, January based
  localparam logic [8:0] CUM_JAN [12] = '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
                                          9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};
  // days before the first of each month, March based
  localparam logic [8:0] CUM_MAR [12] = '{9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
                                          9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337};

  typedef struct packed {
    logic [13:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic        leap;
    logic        eom;
    logic [8:0]  doy;   // zero-based day of year
    logic [12:0] lc;    // leap-day count before the date, offset
    logic [23:0] s;     // day serial
  } date_rec_t;

  typedef struct packed {
    logic        sign;
    logic        one;
    logic        zero;
    logic [13:0] whole;
    logic [22:0] day_total;
  } side_t;

endpackage

`default_nettype wire

// File: src/day_count_year_fraction.sv
// ----------------------------------------------------------------------------
// day_count_year_fraction
// Signed day count and fixed-point year fraction for a pair of dates.
// ----------------------------------------------------------------------------
//  channel  direction  beat contents (lowest bits first)
//  in_      slave      tdata: start, end, ref start, ref end (23b each)
//                      tuser: ref_start_valid, ref_end_valid
//  out_     master     tdata: day_total (23b signed), year_frac (63b signed)
//  cfg_     slave      cfg_index / cfg_data: 0 convention, 1 events per year
//
//  One beat per clock in and out while out_ does not stall. Stages, in order:
//  three decode stages, three selection stages, one
//  divider stage per quotient bit (FRACTION_BITS + 25) and the output register.
//  The divider array sets the depth.
//  Synchronous active-low reset clears valid bits and configuration
//  (convention Act/360, one event per year); payload registers are not reset.
//  A stall on out_ freezes the whole pipeline; in_tready drops with it.
//  Configuration is taken every cycle and is read live by the selection stage.
// ----------------------------------------------------------------------------
`default_nettype none

module day_count_year_fraction #(
  parameter int FRACTION_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // start_date, end_date, ref_start_date, ref_end_date, pad
  input  logic [1:0]  in_tuser,   // ref_start_valid, ref_end_valid
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // day_total, year_frac, pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

`include "day_count_year_fraction_assert.svh"

  localparam int NUM_W = dcyf_pkg::MAG_W + FRACTION_BITS + 1;
  localparam int MW    = (NUM_W + 1 > 63) ? NUM_W + 1 : 63;

  // pipeline advances whenever the output register is free or drained
  logic en;
  logic out_valid_r;
  assign en         = !out_valid_r || out_tready;
  assign in_tready  = en;
  assign out_tvalid = out_valid_r;

  // configuration registers
  logic [3:0] conv_r, epy_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_r <= dcyf_pkg::CONV_ACT360;
      epy_r  <= 4'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        dcyf_pkg::CFG_CONVENTION: conv_r <= cfg_data;
        dcyf_pkg::CFG_EVENTS:     epy_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // date decode
  logic [22:0]         dates [4];
  logic                u_valid;
  dcyf_pkg::date_rec_t u_rec [4];
  logic [1:0]          u_flags;

  assign dates[0] = in_tdata[22:0];
  assign dates[1] = in_tdata[45:23];
  assign dates[2] = in_tdata[68:46];
  assign dates[3] = in_tdata[91:69];

  dcyf_unpack u_unpack (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_tvalid && in_tready),
    .date_i  (dates),
    .flags_i (in_tuser),
    .valid_o (u_valid),
    .rec_o   (u_rec),
    .flags_o (u_flags)
  );

  // convention selection
  logic                       s_valid;
  logic [NUM_W-1:0]           s_num;
  logic [dcyf_pkg::DEN_W-1:0] s_den;
  dcyf_pkg::side_t            s_side;

  dcyf_select #(
    .FRACTION_BITS (FRACTION_BITS),
    .NUM_W         (NUM_W)
  ) u_select (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (en),
    .convention      (conv_r),
    .coupon_freq     (epy_r),
    .valid_i         (u_valid),
    .rec_i           (u_rec),
    .flags_i         (u_flags),
    .valid_o         (s_valid),
    .num_o           (s_num),
    .den_o           (s_den),
    .side_o          (s_side)
  );

  // rounded quotient
  logic             d_valid;
  logic [NUM_W-1:0] d_quo;
  dcyf_pkg::side_t  d_side;

  dcyf_div #(
    .NUM_W (NUM_W),
    .DEN_W (dcyf_pkg::DEN_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (s_valid),
    .num_i   (s_num),
    .den_i   (s_den),
    .side_i  (s_side),
    .valid_o (d_valid),
    .quo_o   (d_quo),
    .side_o  (d_side)
  );

  // output stage: whole years, 1/1, saturation, sign
  logic [MW-1:0] mag;
  logic [62:0]   mag_sat, frac_nxt;
  logic [22:0]   out_day_r;
  logic [62:0]   out_frac_r;

  always_comb begin
    if (d_side.zero)      mag = '0;
    else if (d_side.one)  mag = MW'(1) << FRACTION_BITS;
    else                  mag = MW'(d_quo) + (MW'(d_side.whole) << FRACTION_BITS);
    // magnitude tops out at 2^62 - 1
    mag_sat  = (|mag[MW-1:62]) ? {1'b0, {62{1'b1}}} : mag[62:0];
    frac_nxt = d_side.sign ? (63'd0 - mag_sat) : mag_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= d_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_day_r  <= d_side.day_total;
      out_frac_r <= frac_nxt;
    end
  end

  assign out_tdata = {2'b00, out_frac_r, out_day_r};

  // no days means no fraction; signs of the two results agree
  `DCYF_ASSERT_IMP(a_zero_days_zero_frac, out_valid_r && out_day_r == 23'd0, out_frac_r == 63'd0)
  `DCYF_ASSERT_IMP(a_pos_days_pos_frac, out_valid_r && !out_day_r[22], !out_frac_r[62])
  `DCYF_ASSERT_IMP(a_neg_days_neg_frac, out_valid_r && out_day_r[22], out_frac_r[62] || out_frac_r == 63'd0)

endmodule

`default_nettype wire

// File: src/dcyf_unpack.sv
// ----------------------------------------------------------------------------
// dcyf_unpack
// Three-stage date decode: clamp fields, leap test, day serial.
// ----------------------------------------------------------------------------
`default_nettype none

module dcyf_unpack (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_i,
  input  logic [22:0]          date_i [4],
  input  logic [1:0]           flags_i,
  output logic                 valid_o,
  output dcyf_pkg::date_rec_t  rec_o [4],
  output logic [1:0]           flags_o
);

  logic       v1_r, v2_r, v3_r;
  logic [1:0] f1_r, f2_r, f3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r <= flags_i;
      f2_r <= f1_r;
      f3_r <= f2_r;
    end
  end

  assign valid_o = v3_r;
  assign flags_o = f3_r;

  for (genvar g = 0; g < 4; g++) begin : g_lane
    logic [13:0] y;
    logic [3:0]  mr, m;
    logic [14:0] yy;
    logic [32:0] p_yy, p_y;

    logic [13:0] y1_r;
    logic [3:0]  m1_r;
    logic [4:0]  dr1_r;
    logic [14:0] yy1_r;
    logic [7:0]  qyy1_r, qy1_r;

    logic        leap;
    logic [4:0]  dim, d;
    logic [3:0]  mm;
    logic [8:0]  part;

    dcyf_pkg::date_rec_t rec2_nxt, rec2_r, rec3_nxt, rec3_r;
    logic [14:0] yy2_r;
    logic [8:0]  part2_r;

    // stage 1: field clamp and reciprocal products for /100
    always_comb begin
      y    = date_i[g][22:9];
      mr   = date_i[g][8:5];
      m    = (mr == 4'd0) ? 4'd1 : ((mr > 4'd12) ? 4'd12 : mr);
      yy   = {1'b0, y} + ((m < 4'd3) ? 15'd399 : 15'd400);
      p_yy = 33'(yy) * 33'(dcyf_pkg::RECIP100);
      p_y  = 33'(y) * 33'(dcyf_pkg::RECIP100);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        y1_r   <= y;
        m1_r   <= m;
        dr1_r  <= date_i[g][4:0];
        yy1_r  <= yy;
        qyy1_r <= p_yy[dcyf_pkg::RECIP_SHIFT +: 8];
        qy1_r  <= p_y[dcyf_pkg::RECIP_SHIFT +: 8];
      end
    end

    // stage 2: leap year, day clamp, leap-day count, partial serial
    always_comb begin
      leap = (y1_r[1:0] == 2'b00) &&
             (({1'b0, y1_r} != 15'(qy1_r) * 15'd100) || (qy1_r[1:0] == 2'b00));
      dim  = (m1_r == 4'd2 && leap) ? 5'd29 : dcyf_pkg::MONTH_LEN[m1_r - 4'd1];
      d    = (dr1_r == 5'd0) ? 5'd1 : ((dr1_r > dim) ? dim : dr1_r);
      mm   = (m1_r < 4'd3) ? (m1_r + 4'd9) : (m1_r - 4'd3);
      part = dcyf_pkg::CUM_MAR[mm] + 9'(d) - 9'd1;

      rec2_nxt      = '0;
      rec2_nxt.y    = y1_r;
      rec2_nxt.m    = m1_r;
      rec2_nxt.d    = d;
      rec2_nxt.leap = leap;
      rec2_nxt.eom  = (d == dim);
      rec2_nxt.doy  = dcyf_pkg::CUM_JAN[m1_r - 4'd1] + 9'(m1_r >= 4'd3 && leap)
                      + 9'(d) - 9'd1;
      rec2_nxt.lc   = 13'(yy1_r >> 2) - 13'(qyy1_r) + 13'(qyy1_r >> 2);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rec2_r  <= rec2_nxt;
        yy2_r   <= yy1_r;
        part2_r <= part;
      end
    end

    // stage 3: serial = 365*yy + leap days + day within the March year
    always_comb begin
      rec3_nxt   = rec2_r;
      rec3_nxt.s = 24'(yy2_r) * 24'd365 + 24'(rec2_r.lc) + 24'(part2_r);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rec3_r <= rec3_nxt;
      end
    end

    assign rec_o[g] = rec3_r;
  end

endmodule

`default_nettype wire

// File: src/dcyf_select.sv
// ----------------------------------------------------------------------------
// dcyf_select
// Order the dates, form day count, numerator and denominator per convention.
// ----------------------------------------------------------------------------
`default_nettype none

module dcyf_select #(
  parameter int FRACTION_BITS = 32,
  parameter int NUM_W         = dcyf_pkg::MAG_W + FRACTION_BITS + 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic [3:0]                convention,
  input  logic [3:0]                coupon_freq,
  input  logic                      valid_i,
  input  dcyf_pkg::date_rec_t       rec_i [4],
  input  logic [1:0]                flags_i,
  output logic                      valid_o,
  output logic [NUM_W-1:0]          num_o,
  output logic [dcyf_pkg::DEN_W-1:0] den_o,
  output dcyf_pkg::side_t           side_o
);

  localparam int DTW = dcyf_pkg::DT_W;

  // ---- stage 1: swap, differences --------------------------------------
  dcyf_pkg::date_rec_t a, b, ra, rb, rs, re;
  logic               swap, va, vb;
  logic [22:0]        diff, rd;
  logic signed [DTW-1:0] dt_nl, t30, dt, yd, md, dd, rdi;
  logic [4:0]         td1, td2;
  logic [8:0]         ta, tb;
  logic [13:0]        w;

  logic               v1_r, neg1_r, same1_r, la1_r, lb1_r;
  logic [3:0]         conv1_r, f1_r;
  logic [22:0]        diff1_r, rd1_r;
  logic signed [DTW-1:0] dt1_r;
  logic [8:0]         ta1_r, tb1_r;
  logic [13:0]        w1_r;

  always_comb begin
    swap = rec_i[1].s < rec_i[0].s;
    a    = swap ? rec_i[1] : rec_i[0];
    b    = swap ? rec_i[0] : rec_i[1];
    ra   = swap ? rec_i[3] : rec_i[2];
    rb   = swap ? rec_i[2] : rec_i[3];
    va   = swap ? flags_i[1] : flags_i[0];
    vb   = swap ? flags_i[0] : flags_i[1];
    diff = 23'(b.s - a.s);

    dt_nl = $signed(DTW'(diff)) - ($signed(DTW'(b.lc)) - $signed(DTW'(a.lc)));

    td1 = a.d;
    td2 = b.d;
    case (convention)
      dcyf_pkg::CONV_30US: begin
        if (a.d == 5'd31) td1 = 5'd30;
        if (b.d == 5'd31 && td1 >= 5'd30) td2 = 5'd30;
      end
      dcyf_pkg::CONV_30E: begin
        if (a.d == 5'd31) td1 = 5'd30;
        if (b.d == 5'd31) td2 = 5'd30;
      end
      default: begin
        if (a.eom) td1 = 5'd30;
        if (b.eom && b.m != 4'd2) td2 = 5'd30;
      end
    endcase
    yd  = $signed(DTW'(b.y)) - $signed(DTW'(a.y));
    md  = $signed(DTW'(b.m)) - $signed(DTW'(a.m));
    dd  = $signed(DTW'(td2)) - $signed(DTW'(td1));
    t30 = yd * 25'sd360 + md * 25'sd30 + dd;

    case (convention)
      dcyf_pkg::CONV_ACT365NL: dt = dt_nl;
      dcyf_pkg::CONV_30US,
      dcyf_pkg::CONV_30E,
      dcyf_pkg::CONV_30EISDA:  dt = t30;
      default:                 dt = $signed(DTW'(diff));
    endcase

    // reference period; a non-positive length falls back to the actual one
    rs  = va ? ra : a;
    re  = vb ? rb : b;
    rdi = $signed(DTW'(re.s)) - $signed(DTW'(rs.s));
    rd  = (rdi <= 0) ? diff : rdi[22:0];

    ta = (a.leap ? 9'd366 : 9'd365) - a.doy;
    tb = b.doy;
    w  = b.y - a.y - 14'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= valid_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      conv1_r <= convention;
      f1_r    <= (coupon_freq == 4'd0) ? 4'd1 : coupon_freq;
      neg1_r  <= swap;
      diff1_r <= diff;
      dt1_r   <= dt;
      rd1_r   <= rd;
      same1_r <= (a.y == b.y);
      la1_r   <= a.leap;
      lb1_r   <= b.leap;
      ta1_r   <= ta;
      tb1_r   <= tb;
      w1_r    <= w;
    end
  end

  // ---- stage 2: numerator magnitude, denominator, day total --------------
  logic signed [DTW-1:0] n, tot;
  logic [8:0]   d1, d2;
  logic [dcyf_pkg::MAG_W-1:0] mag, nabs;
  logic [dcyf_pkg::DEN_W-1:0] den;
  logic         fneg;
  dcyf_pkg::side_t side2_nxt, side2_r;
  logic         v2_r;
  logic [dcyf_pkg::MAG_W-1:0] mag2_r;
  logic [dcyf_pkg::DEN_W-1:0] den2_r;

  always_comb begin
    d1 = la1_r ? 9'd366 : 9'd365;
    d2 = lb1_r ? 9'd366 : 9'd365;
    case (conv1_r)
      dcyf_pkg::CONV_ACT365NL,
      dcyf_pkg::CONV_30US,
      dcyf_pkg::CONV_30E,
      dcyf_pkg::CONV_30EISDA: n = dt1_r;
      default:                n = $signed(DTW'(diff1_r));
    endcase
    fneg = n[DTW-1];
    nabs = fneg ? 24'(-n) : 24'(n);

    mag = nabs;
    side2_nxt       = '0;
    side2_nxt.whole = 14'd0;
    case (conv1_r)
      dcyf_pkg::CONV_ACT360,
      dcyf_pkg::CONV_30US,
      dcyf_pkg::CONV_30E,
      dcyf_pkg::CONV_30EISDA: den = 27'd360;
      dcyf_pkg::CONV_ISDA: begin
        if (same1_r) begin
          den = 27'(d1);
        end else begin
          den = 27'(18'(d1) * 18'(d2));
          mag = 24'(19'(ta1_r) * 19'(d2) + 19'(tb1_r) * 19'(d1));
          side2_nxt.whole = w1_r;
        end
      end
      dcyf_pkg::CONV_ICMA: den = 27'(f1_r) * 27'(rd1_r);
      dcyf_pkg::CONV_ONE:  den = 27'd1;
      default:             den = 27'd365;
    endcase

    tot = neg1_r ? -dt1_r : dt1_r;
    if (tot > $signed(DTW'(dcyf_pkg::DAY_LIMIT))) tot = $signed(DTW'(dcyf_pkg::DAY_LIMIT));
    if (tot < -$signed(DTW'(dcyf_pkg::DAY_LIMIT))) tot = -$signed(DTW'(dcyf_pkg::DAY_LIMIT));

    side2_nxt.sign      = neg1_r ^ fneg;
    side2_nxt.one       = (conv1_r == dcyf_pkg::CONV_ONE);
    side2_nxt.zero      = (diff1_r == 23'd0);
    side2_nxt.day_total = tot[22:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag2_r  <= mag;
      den2_r  <= den;
      side2_r <= side2_nxt;
    end
  end

  // ---- stage 3: rounding bias, numerator scaled to fixed point -----------
  logic                       v3_r;
  logic [NUM_W-1:0]           num3_r;
  logic [dcyf_pkg::DEN_W-1:0] den3_r;
  dcyf_pkg::side_t            side3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num3_r  <= (NUM_W'(mag2_r) << FRACTION_BITS) + NUM_W'(den2_r >> 1);
      den3_r  <= den2_r;
      side3_r <= side2_r;
    end
  end

  assign valid_o = v3_r;
  assign num_o   = num3_r;
  assign den_o   = den3_r;
  assign side_o  = side3_r;

endmodule

`default_nettype wire

// File: src/dcyf_div.sv
// ----------------------------------------------------------------------------
// dcyf_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dcyf_div #(
  parameter int NUM_W = 57,
  parameter int DEN_W = 27
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  dcyf_pkg::side_t  side_i,
  output logic             valid_o,
  output logic [NUM_W-1:0] quo_o,
  output dcyf_pkg::side_t  side_o
);

  // numerator bits leave at the top while quotient bits enter at the bottom
  logic             v_r    [NUM_W];
  logic [DEN_W-1:0] rem_r  [NUM_W];
  logic [NUM_W-1:0] nq_r   [NUM_W];
  logic [DEN_W-1:0] den_r  [NUM_W];
  dcyf_pkg::side_t  side_r [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic             v_in;
    logic [DEN_W-1:0] rem_in, den_in, rem_nxt;
    logic [NUM_W-1:0] nq_in;
    dcyf_pkg::side_t  side_in;
    logic [DEN_W:0]   t;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign nq_in   = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign nq_in   = nq_r[k-1];
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      t       = {rem_in, nq_in[NUM_W-1]};
      ge      = (t >= {1'b0, den_in});
      rem_nxt = ge ? DEN_W'(t - {1'b0, den_in}) : DEN_W'(t);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k] <= 1'b0;
      else if (en) v_r[k] <= v_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        nq_r[k]   <= {nq_in[NUM_W-2:0], ge};
        den_r[k]  <= den_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign valid_o = v_r[NUM_W-1];
  assign quo_o   = nq_r[NUM_W-1];
  assign side_o  = side_r[NUM_W-1];

endmodule

`default_nettype wire

// File: verif/tb_day_count_year_fraction.sv
// ----------------------------------------------------------------------------
// tb_day_count_year_fraction
// Self-checking bench for the day-count year-fraction block. A built-in
// calendar predictor computes the day total and Q32 year fraction for each
// accepted beat; results are compared in order. Directed corner dates run
// per convention, then random date pairs under many register settings, with
// bursty input, random output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_day_count_year_fraction;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 32;                      // fraction bits of the block
  localparam longint DAY_MAX = 3652059;
  localparam longint unsigned MAG_MAX = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam int DRAIN_CYCLES = 100;           // pipeline depth is 64 at FB = 32
  localparam logic [22:0] DATE_MIN = 23'd512;
  localparam logic [22:0] DATE_MAX = 23'd5119903;
  localparam int MDAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct {
    logic [22:0] start_d, stop_d, ref_start_d, ref_stop_d;
    logic        ref_start_ok, ref_stop_ok;
  } date_pair_t;

  typedef struct {
    logic [22:0] day_total;
    logic [62:0] year_frac;
  } accrual_t;

  typedef struct {
    longint y, m, d, s;
  } cal_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;   // start, end, ref start, ref end (23b each), pad
  logic [1:0]  in_tuser = '0;   // ref_start_valid, ref_end_valid
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;       // day_total (23b), year_frac (63b), pad
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [3:0]  cfg_data = '0;

  // shadow of the block's registers
  logic [3:0] conv_cfg = dcyf_pkg::CONV_ACT360;
  logic [3:0] events_cfg = 4'd1;

  accrual_t accrual_q[$];
  int errors = 0;
  int burst_left = 0;
  int max_gap = 3;
  int stall_pct = 0;
  int hold_cnt = 0;

  day_count_year_fraction dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic bit leap_yr(longint y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic longint month_days(longint y, longint m);
    if (m == 2 && leap_yr(y)) return 29;
    return MDAYS[m - 1];
  endfunction

  // serial day number; +400 years keeps all terms non-negative
  function automatic longint day_serial(longint y, longint m, longint d);
    longint yy, mm;
    yy = y + 400;
    if (m < 3) begin
      yy -= 1;
      mm = m + 9;
    end else begin
      mm = m - 3;
    end
    return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mm + 2) / 5 + d - 1;
  endfunction

  // clamp month to 1..12, day to 1..end of month
  function automatic cal_t decode_date(logic [22:0] p);
    cal_t r;
    longint dim;
    r.y = p[22:9];
    r.m = p[8:5];
    r.d = p[4:0];
    if (r.m < 1) r.m = 1;
    if (r.m > 12) r.m = 12;
    dim = month_days(r.y, r.m);
    if (r.d < 1) r.d = 1;
    if (r.d > dim) r.d = dim;
    r.s = day_serial(r.y, r.m, r.d);
    return r;
  endfunction

  function automatic longint feb29_count(cal_t t);
    longint yy, c;
    yy = t.y + 399;
    c = yy / 4 - yy / 100 + yy / 400;
    if (t.m >= 3 && leap_yr(t.y)) c += 1;
    return c;
  endfunction

  function automatic longint unsigned round_quot(longint unsigned num, longint unsigned den);
    return (num + den / 2) / den;
  endfunction

  function automatic longint unsigned frac_mag(longint n, longint unsigned den, inout bit neg);
    longint unsigned m;
    if (n < 0) begin
      neg = !neg;
      m = -n;
    end else begin
      m = n;
    end
    return round_quot(m << FB, den);
  endfunction

  function automatic longint thirty_days(cal_t a, cal_t b, logic [3:0] kind);
    longint d1, d2;
    d1 = a.d;
    d2 = b.d;
    if (kind == dcyf_pkg::CONV_30US) begin
      if (d1 == 31) d1 = 30;
      if (d2 == 31 && d1 >= 30) d2 = 30;
    end else if (kind == dcyf_pkg::CONV_30E) begin
      if (d1 == 31) d1 = 30;
      if (d2 == 31) d2 = 30;
    end else begin
      if (a.d == month_days(a.y, a.m)) d1 = 30;
      if (b.d == month_days(b.y, b.m) && b.m != 2) d2 = 30;
    end
    return 360 * (b.y - a.y) + 30 * (b.m - a.m) + (d2 - d1);
  endfunction

  function automatic accrual_t calc_accrual(date_pair_t it);
    accrual_t r;
    cal_t a, b, ra, rb, t;
    bit va, vb, neg, fneg, swp;
    longint diff, dt, tot, rd;
    longint unsigned mag, d1, d2, ta, tb, f;
    a = decode_date(it.start_d);
    b = decode_date(it.stop_d);
    ra = decode_date(it.ref_start_d);
    rb = decode_date(it.ref_stop_d);
    va = it.ref_start_ok;
    vb = it.ref_stop_ok;
    neg = 1'b0;
    fneg = 1'b0;
    mag = 0;
    // reversed pair: order it, reference dates swap along, negate at the end
    swp = b.s < a.s;
    if (swp) begin
      t = a; a = b; b = t;
      t = ra; ra = rb; rb = t;
      {va, vb} = {vb, va};
      neg = 1'b1;
    end
    diff = b.s - a.s;
    if (conv_cfg == dcyf_pkg::CONV_ACT365NL) dt = diff - (feb29_count(b) - feb29_count(a));
    else if (conv_cfg >= dcyf_pkg::CONV_30US && conv_cfg <= dcyf_pkg::CONV_30EISDA)
      dt = thirty_days(a, b, conv_cfg);
    else dt = diff;

    if (diff != 0) begin
      case (conv_cfg)
        dcyf_pkg::CONV_ACT360:   mag = frac_mag(diff, 360, fneg);
        dcyf_pkg::CONV_ACT365NL: mag = frac_mag(dt, 365, fneg);
        dcyf_pkg::CONV_ISDA: begin
          d1 = leap_yr(a.y) ? 366 : 365;
          if (a.y == b.y) begin
            mag = frac_mag(diff, d1, fneg);
          end else begin
            // two stub years over a common denominator, then whole years
            d2 = leap_yr(b.y) ? 366 : 365;
            ta = day_serial(a.y + 1, 1, 1) - a.s;
            tb = b.s - day_serial(b.y, 1, 1);
            mag = round_quot((ta * d2 + tb * d1) << FB, d1 * d2);
            mag += longint'(b.y - a.y - 1) << FB;
          end
        end
        dcyf_pkg::CONV_ICMA: begin
          rd = (vb ? rb.s : b.s) - (va ? ra.s : a.s);
          f = (events_cfg != 0) ? events_cfg : 1;
          if (rd <= 0) rd = diff;
          mag = frac_mag(diff, f * rd, fneg);
        end
        dcyf_pkg::CONV_30US, dcyf_pkg::CONV_30E, dcyf_pkg::CONV_30EISDA:
          mag = frac_mag(dt, 360, fneg);
        dcyf_pkg::CONV_ONE: mag = 64'd1 << FB;
        default:  mag = frac_mag(diff, 365, fneg);  // Act/365F and unused codes
      endcase
      if (fneg) neg = !neg;
    end
    if (mag > MAG_MAX) mag = MAG_MAX;
    tot = swp ? -dt : dt;
    if (tot > DAY_MAX) tot = DAY_MAX;
    if (tot < -DAY_MAX) tot = -DAY_MAX;
    r.day_total = tot[22:0];
    r.year_frac = neg ? 63'(-mag) : 63'(mag);
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers
  function automatic logic [22:0] pack_date(int y, int m, int d);
    return 23'(y * 512 + m * 32 + d);
  endfunction

  // one beat on in_; valid stays up across a burst, a gap drops it
  task automatic send_pair(date_pair_t it);
    int gap;
    if (burst_left == 0) begin
      gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, it.ref_stop_d, it.ref_start_d, it.stop_d, it.start_d};
    in_tuser  <= {it.ref_stop_ok, it.ref_start_ok};
    do @(posedge clk); while (!in_tready);
    accrual_q = {accrual_q, calc_accrual(it)};
    burst_left--;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (accrual_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == dcyf_pkg::CFG_CONVENTION) conv_cfg = val;
    else events_cfg = val;
  endtask

  task automatic set_config(logic [3:0] conv, logic [3:0] events);
    drain();
    write_reg(dcyf_pkg::CFG_CONVENTION, conv);
    write_reg(dcyf_pkg::CFG_EVENTS, events);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [22:0] rand_date(int y, bit is_ref);
    int m, d;
    logic [22:0] p;
    m = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 12) : $urandom_range(0, 15);
    case ($urandom_range(0, 5))
      0:       d = $urandom_range(0, 31);          // includes malformed days
      1:       d = $urandom_range(28, 31);         // month-end region
      default: d = $urandom_range(1, 28);
    endcase
    p = pack_date(y, m, d);
    if (p > DATE_MAX) p = DATE_MAX;
    if (!is_ref && p < DATE_MIN) p = DATE_MIN;
    return p;
  endfunction

  function automatic date_pair_t rand_pair();
    date_pair_t it;
    int y1, y2;
    y1 = ($urandom_range(0, 4) != 0) ? $urandom_range(1900, 2100) : $urandom_range(1, 9999);
    y2 = ($urandom_range(0, 9) != 0) ? y1 + $urandom_range(0, 6) - 2 : $urandom_range(1, 9999);
    if (y2 < 1) y2 = 1;
    if (y2 > 9999) y2 = 9999;
    it.start_d = rand_date(y1, 1'b0);
    it.stop_d  = ($urandom_range(0, 19) == 0) ? it.start_d : rand_date(y2, 1'b0);
    it.ref_start_d = ($urandom_range(0, 9) == 0) ? 23'd0 : rand_date(y1, 1'b1);
    it.ref_stop_d  = ($urandom_range(0, 9) == 0) ? 23'd0
                   : rand_date(y1 + $urandom_range(0, 1), 1'b1);
    it.ref_start_ok = $urandom_range(0, 1);
    it.ref_stop_ok  = $urandom_range(0, 1);
    return it;
  endfunction

  function automatic date_pair_t mk_pair(logic [22:0] s, logic [22:0] e,
                                         logic [22:0] rs = 0, logic [22:0] re = 0,
                                         bit rsv = 0, bit rev = 0);
    date_pair_t it;
    it.start_d = s;
    it.stop_d = e;
    it.ref_start_d = rs;
    it.ref_stop_d = re;
    it.ref_start_ok = rsv;
    it.ref_stop_ok = rev;
    return it;
  endfunction

  // ---------------------------------------------------------------- receiver
  // random stall pattern, overridden by a long hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    accrual_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (accrual_q.size() == 0) begin
        $display("%t: unexpected result beat, actual %h", $realtime, out_tdata);
        errors++;
      end else begin
        exp_r = accrual_q.pop_front();
        if (out_tdata[22:0] !== exp_r.day_total) begin
          $display("%t: day_total expected %0d actual %0d", $realtime,
                   $signed(exp_r.day_total), $signed(out_tdata[22:0]));
          errors++;
        end
        if (out_tdata[85:23] !== exp_r.year_frac) begin
          $display("%t: year frac expected %h actual %h", $realtime,
                   exp_r.year_frac, out_tdata[85:23]);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests
  // corner dates, each under the convention where it matters
  task automatic test_corner_dates;
    max_gap = 0;
    set_config(dcyf_pkg::CONV_ACT360, 4'd1);
    send_pair(mk_pair(pack_date(1, 1, 1), pack_date(9999, 12, 31)));  // widest span
    send_pair(mk_pair(pack_date(9999, 15, 31), DATE_MIN));           // reversed, clamped
    set_config(dcyf_pkg::CONV_ACT365F, 4'd1);
    send_pair(mk_pair(pack_date(2020, 5, 5), pack_date(2020, 5, 5)));  // equal dates
    send_pair(mk_pair(pack_date(2021, 0, 0), pack_date(2021, 2, 31))); // month/day fixups
    set_config(dcyf_pkg::CONV_ACT365NL, 4'd1);
    send_pair(mk_pair(pack_date(2024, 2, 1), pack_date(2024, 3, 15))); // over Feb 29
    send_pair(mk_pair(pack_date(2028, 3, 1), pack_date(2019, 1, 9)));
    set_config(dcyf_pkg::CONV_ISDA, 4'd1);
    send_pair(mk_pair(pack_date(2023, 7, 1), pack_date(2025, 3, 1)));
    send_pair(mk_pair(pack_date(2024, 1, 10), pack_date(2024, 11, 30)));
    set_config(dcyf_pkg::CONV_ICMA, 4'd2);
    send_pair(mk_pair(pack_date(2024, 1, 15), pack_date(2024, 4, 1),
                      pack_date(2024, 1, 15), pack_date(2024, 7, 15), 1, 1));
    send_pair(mk_pair(pack_date(2024, 4, 1), pack_date(2024, 1, 15),  // empty ref period
                      pack_date(2024, 3, 3), pack_date(2024, 3, 3), 1, 1));
    send_pair(mk_pair(pack_date(2024, 1, 15), pack_date(2024, 1, 16),
                      23'h7FFFFF, 23'd0, 0, 1));
    set_config(dcyf_pkg::CONV_30US, 4'd1);
    send_pair(mk_pair(pack_date(2023, 1, 31), pack_date(2023, 3, 31)));
    send_pair(mk_pair(pack_date(2023, 2, 28), pack_date(2023, 3, 31)));
    set_config(dcyf_pkg::CONV_30E, 4'd1);
    send_pair(mk_pair(pack_date(2023, 5, 31), pack_date(2023, 8, 31)));
    set_config(dcyf_pkg::CONV_30EISDA, 4'd1);
    send_pair(mk_pair(pack_date(2024, 2, 29), pack_date(2025, 2, 28))); // Feb end kept
    send_pair(mk_pair(pack_date(2023, 4, 30), pack_date(2023, 5, 31)));
    set_config(dcyf_pkg::CONV_ONE, 4'd1);
    send_pair(mk_pair(pack_date(2030, 1, 1), pack_date(2025, 6, 6)));
    send_pair(mk_pair(pack_date(2030, 1, 1), pack_date(2030, 1, 1)));
    set_config(4'd12, 4'd15);                                         // unused code
    send_pair(mk_pair(pack_date(2000, 1, 1), pack_date(2001, 1, 1)));
  endtask

  // random pairs across every convention code and frequency extremes
  task automatic test_random_pairs;
    logic [3:0] ev;
    for (int c = 0; c < 16; c++) begin
      ev = (c == 4) ? 4'd0 : (c == 9) ? 4'd12 : (c == 10) ? 4'd15 : 4'($urandom_range(0, 15));
      set_config(4'(c), ev);
      max_gap   = (c % 3 == 0) ? 0 : $urandom_range(1, 6);
      stall_pct = (c % 4 == 0) ? 0 : $urandom_range(10, 60);
      repeat ((c <= 8) ? 150 : 40) send_pair(rand_pair());
    end
    // ICMA again at a few frequencies, where reference dates count
    for (int k = 0; k < 3; k++) begin
      set_config(dcyf_pkg::CONV_ICMA, 4'($urandom_range(1, 15)));
      repeat (60) send_pair(rand_pair());
    end
  endtask

  // long output hold-off while input keeps coming: pipeline fills, in_tready drops
  task automatic test_output_holdoff;
    set_config(dcyf_pkg::CONV_ISDA, 4'd1);
    max_gap = 0;
    stall_pct = 20;
    hold_cnt = 400;
    repeat (150) send_pair(rand_pair());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_dates();
    test_random_pairs();
    test_output_holdoff();
    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
